### rtl/dbcm_pkg.sv
package dbcm_pkg;

  // Object index field width and the number of entries it can reach
  localparam int IDX_W           = 6;
  localparam int OBJ_SPAN        = 2 ** IDX_W;
  localparam int NUM_OBJECTS_DEF = 64;
  localparam int WORD_W          = 32;

  // Command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_COMMIT = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  object_index;
    logic [WORD_W-1:0] address_in;
    logic [WORD_W-1:0] begin_in;
    logic [WORD_W-1:0] end_in;
    logic [WORD_W-1:0] task_begin;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] address_out;
    logic [WORD_W-1:0] begin_out;
    logic [WORD_W-1:0] end_out;
    logic [WORD_W-1:0] task_begin_out;
  } out_item_t;

  // One stored copy of an object
  typedef struct packed {
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] vbeg;
    logic [WORD_W-1:0] vend;
  } copy_t;

  localparam int COPY_W = $bits(copy_t);

endpackage

### rtl/dbcm_ram.sv
module dbcm_ram #(
  parameter int W     = 1,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;
  logic         rd_vld_r;
  logic [DEPTH-1:0] vld_r;

  // Storage array: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Track which entries have been written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // Unwritten entries read as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### rtl/double_buffered_commit_map.sv
// Per-object double-buffered map. Each object keeps two copies of
// {address, begin stamp, end stamp} and a selector naming the live copy. A
// commit transaction (cmd = 1) writes the shadow copy and flips the selector;
// it gives no result. A lookup transaction (cmd = 0) returns the live copy and
// task_begin raised to max(task_begin, live begin + 1), the sum wrapping at
// 32 bits. One transaction is accepted per cycle; a lookup result passes
// through the stage one register and is registered on out_data. The copy and
// selector memories are read at accept, and commits write them back from
// stage one in the next cycle with forwarding of the previous commit; only a
// stalled output holds the input side. Object indexes at or above NUM_OBJECTS
// are ignored by commits and read as all-zero entries by lookups. All entries
// read as zero after reset through per-entry written flags, so no clearing
// pass is needed and the block is ready right after reset.
module double_buffered_commit_map
  import dbcm_pkg::*;
#(
  parameter int NUM_OBJECTS = NUM_OBJECTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int DEPTH = (NUM_OBJECTS < OBJ_SPAN) ? NUM_OBJECTS : OBJ_SPAN;
  localparam int AW    = $clog2(DEPTH);

  logic      in_accept;
  logic      in_range;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      s1_range_r;
  logic      s1_fwd_r;
  logic      s1_fwd_nxt;
  logic      s1_adv;
  logic      s1_commit;
  logic      fwd_sel_r;
  copy_t     fwd_copy_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  logic [0:0]  sel_rd;
  logic [COPY_W-1:0] a_rd;
  logic [COPY_W-1:0] b_rd;
  logic        cur_sel;
  copy_t       copy_a;
  copy_t       copy_b;
  copy_t       live;
  copy_t       wr_copy;
  logic        wr_en;
  logic        wr_a;
  logic        wr_b;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [WORD_W-1:0] raised;

  // Handshake
  assign s1_commit = (s1_item_r.cmd == CMD_COMMIT);
  assign s1_adv    = s1_valid_r && (s1_commit || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;
  assign in_range  = (32'(in_data.object_index) < 32'(NUM_OBJECTS));

  assign rd_addr = in_data.object_index[AW-1:0];
  assign wr_addr = s1_item_r.object_index[AW-1:0];

  // In-range commits in stage one write back in the cycle they sit there
  assign wr_en = s1_valid_r && s1_commit && s1_range_r;

  // Flag a read that raced a write to the same entry
  assign s1_fwd_nxt = wr_en && (in_data.object_index == s1_item_r.object_index);

  // Merge the last committed copy over stale read data
  assign cur_sel = s1_fwd_r ? fwd_sel_r : sel_rd[0];
  assign copy_a  = (s1_fwd_r && !fwd_sel_r) ? fwd_copy_r : copy_t'(a_rd);
  assign copy_b  = (s1_fwd_r && fwd_sel_r) ? fwd_copy_r : copy_t'(b_rd);

  always_comb begin
    if (!s1_range_r) begin
      live = '0;
    end else if (cur_sel) begin
      live = copy_b;
    end else begin
      live = copy_a;
    end
  end

  // Write the shadow copy: A when B is live, B when A is live
  assign wr_a = wr_en && cur_sel;
  assign wr_b = wr_en && !cur_sel;
  assign wr_copy.addr = s1_item_r.address_in;
  assign wr_copy.vbeg = s1_item_r.begin_in;
  assign wr_copy.vend = s1_item_r.end_in;

  // Lookup result
  assign raised = live.vbeg + WORD_W'(1);
  always_comb begin
    out_data_nxt.address_out    = live.addr;
    out_data_nxt.begin_out      = live.vbeg;
    out_data_nxt.end_out        = live.vend;
    out_data_nxt.task_begin_out = (s1_item_r.task_begin > raised) ?
                                  s1_item_r.task_begin : raised;
  end

  // Stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
      s1_fwd_r   <= s1_fwd_nxt;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r  <= in_data;
      s1_range_r <= in_range;
    end
  end

  // Hold the last committed copy for forwarding
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_sel_r  <= !cur_sel;
      fwd_copy_r <= wr_copy;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && !s1_commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !s1_commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Selector and the two copies
  dbcm_ram #(
    .W     (1),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_sel_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (sel_rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (!cur_sel)
  );

  dbcm_ram #(
    .W     (COPY_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_copy_a_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (a_rd),
    .wr_en   (wr_a),
    .wr_addr (wr_addr),
    .wr_data (wr_copy)
  );

  dbcm_ram #(
    .W     (COPY_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_copy_b_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (b_rd),
    .wr_en   (wr_b),
    .wr_addr (wr_addr),
    .wr_data (wr_copy)
  );

  // Checks
  a_commit_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_commit |-> s1_adv)
    else $error("commit held in stage one");

  a_one_copy_written: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_a && wr_b))
    else $error("both copies written at once");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> s1_valid_r)
    else $error("forward flag without a stage one transaction");

  a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && !s1_commit))
    else $error("result without a lookup");

endmodule

### tb/double_buffered_commit_map_tb.sv
`timescale 1ns / 100ps

module double_buffered_commit_map_tb
  import dbcm_pkg::*;
();

  localparam int MAP_DEPTH  = NUM_OBJECTS_DEF;
  localparam int RAND_ITEMS = 1300;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_LEN  = 8;

  localparam logic [WORD_W-1:0] NONE = 32'h0000_0000;
  localparam logic [WORD_W-1:0] ONES = 32'hFFFF_FFFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int tx_idle_pct = 13;
  int rx_idle_pct = 70;
  int hold_requests = 0;
  int mismatches = 0;

  // Shadow of the object map: two copies and the live selector per object
  copy_t     copy_a [MAP_DEPTH];
  copy_t     copy_b [MAP_DEPTH];
  bit        live_is_b [MAP_DEPTH];
  out_item_t pending_lookups [$];

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] addr, vbeg, vend, tbeg;
    logic              typed;
    logic [WORD_W-1:0] g_addr, g_beg, g_end, g_tb;
  } stim_row_t;

  // cmd, index, address, begin, end, task begin | typed, address, begin, end, task begin
  stim_row_t directed_rows [20] = '{
    '{CMD_LOOKUP, 6'd0,  NONE, NONE, NONE, NONE, 1'b1, NONE, NONE, NONE, 32'h1},
    '{CMD_LOOKUP, 6'd63, ONES, ONES, ONES, ONES, 1'b1, NONE, NONE, NONE, ONES},
    '{CMD_COMMIT, 6'd0,  ONES, ONES, ONES, NONE, 1'b0, NONE, NONE, NONE, NONE},
    '{CMD_LOOKUP, 6'd0,  NONE, NONE, NONE, 32'h5, 1'b1, ONES, ONES, ONES, 32'h5},
    '{CMD_LOOKUP, 6'd0,  NONE, NONE, NONE, NONE, 1'b1, ONES, ONES, ONES, NONE},
    '{CMD_LOOKUP, 6'd1,  NONE, NONE, NONE, NONE, 1'b1, NONE, NONE, NONE, 32'h1},
    '{CMD_COMMIT, 6'd0,  NONE, NONE, NONE, ONES, 1'b0, NONE, NONE, NONE, NONE},
    '{CMD_LOOKUP, 6'd0,  ONES, ONES, ONES, NONE, 1'b1, NONE, NONE, NONE, 32'h1},
    '{CMD_COMMIT, 6'd63, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, NONE,
      1'b0, NONE, NONE, NONE, NONE},
    '{CMD_LOOKUP, 6'd63, NONE, NONE, NONE, NONE,
      1'b1, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000},
    '{CMD_LOOKUP, 6'd63, NONE, NONE, NONE, ONES,
      1'b1, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, ONES},
    '{CMD_COMMIT, 6'd63, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, NONE,
      1'b0, NONE, NONE, NONE, NONE},
    '{CMD_COMMIT, 6'd63, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, NONE,
      1'b0, NONE, NONE, NONE, NONE},
    '{CMD_LOOKUP, 6'd63, NONE, NONE, NONE, 32'hAAAA_AAAB, 1'b0, NONE, NONE, NONE, NONE},
    '{CMD_LOOKUP, 6'd63, NONE, NONE, NONE, 32'hAAAA_AAAA, 1'b0, NONE, NONE, NONE, NONE},
    '{CMD_COMMIT, 6'd21, 32'h0000_ABCD, 32'h100, 32'h200, NONE,
      1'b0, NONE, NONE, NONE, NONE},
    '{CMD_LOOKUP, 6'd21, NONE, NONE, NONE, 32'h100, 1'b0, NONE, NONE, NONE, NONE},
    '{CMD_LOOKUP, 6'd21, NONE, NONE, NONE, 32'h102, 1'b0, NONE, NONE, NONE, NONE},
    '{CMD_COMMIT, 6'd42, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'h1, NONE,
      1'b0, NONE, NONE, NONE, NONE},
    '{CMD_LOOKUP, 6'd42, NONE, NONE, NONE, 32'hFFFF_FFFE, 1'b0, NONE, NONE, NONE, NONE}
  };

  double_buffered_commit_map dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Live copy of one object; indexes past the map read as an all-zero entry
  function automatic copy_t live_copy(input logic [IDX_W-1:0] idx);
    if (idx >= MAP_DEPTH) return '0;
    return live_is_b[idx] ? copy_b[idx] : copy_a[idx];
  endfunction

  // Apply one accepted transaction to the shadow map and queue its lookup result
  function automatic void track_transaction(input in_item_t t, input logic typed,
                                            input out_item_t golden);
    copy_t             live;
    out_item_t         res;
    logic [WORD_W-1:0] raised;
    if (t.cmd == CMD_COMMIT) begin
      if (t.object_index < MAP_DEPTH) begin
        if (live_is_b[t.object_index]) begin
          copy_a[t.object_index] = '{t.address_in, t.begin_in, t.end_in};
        end else begin
          copy_b[t.object_index] = '{t.address_in, t.begin_in, t.end_in};
        end
        live_is_b[t.object_index] = !live_is_b[t.object_index];
      end
    end else begin
      live   = live_copy(t.object_index);
      raised = live.vbeg + 32'd1;
      res.address_out    = live.addr;
      res.begin_out      = live.vbeg;
      res.end_out        = live.vend;
      res.task_begin_out = (t.task_begin > raised) ? t.task_begin : raised;
      pending_lookups.push_back(typed ? golden : res);
    end
  endfunction

  // Stamps lean toward the extremes so the begin + 1 wrap is hit often
  function automatic logic [WORD_W-1:0] pick_stamp();
    case ($urandom_range(9))
      0:       return NONE;
      1:       return ONES;
      2:       return ONES - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Most traffic goes to a few hot objects so lookups see committed data
  function automatic in_item_t random_item();
    in_item_t t;
    copy_t    live;
    t.cmd = ($urandom_range(99) < 50) ? CMD_COMMIT : CMD_LOOKUP;
    if ($urandom_range(99) < 60) begin
      t.object_index = IDX_W'($urandom_range(3));
    end else begin
      t.object_index = IDX_W'($urandom_range(OBJ_SPAN - 1));
    end
    t.address_in = $urandom;
    t.begin_in   = pick_stamp();
    t.end_in     = pick_stamp();
    live = live_copy(t.object_index);
    case ($urandom_range(3))
      0:       t.task_begin = live.vbeg + $urandom_range(2);
      1:       t.task_begin = pick_stamp();
      default: t.task_begin = $urandom;
    endcase
    return t;
  endfunction

  // Offer one transaction, with an optional idle gap first; hold until accepted
  task automatic offer(input in_item_t t, input logic typed, input out_item_t golden);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    track_transaction(t, typed, golden);
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Check each lookup result against the oldest pending expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        $error("unexpected lookup result %h", out_data);
        mismatches++;
      end else begin
        want = pending_lookups.pop_front();
        if (out_data.address_out !== want.address_out) begin
          $error("address_out expected %h got %h", want.address_out, out_data.address_out);
          mismatches++;
        end
        if (out_data.begin_out !== want.begin_out) begin
          $error("begin_out expected %h got %h", want.begin_out, out_data.begin_out);
          mismatches++;
        end
        if (out_data.end_out !== want.end_out) begin
          $error("end_out expected %h got %h", want.end_out, out_data.end_out);
          mismatches++;
        end
        if (out_data.task_begin_out !== want.task_begin_out) begin
          $error("task_begin_out expected %h got %h", want.task_begin_out,
                 out_data.task_begin_out);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    in_item_t  t;
    out_item_t golden;
    for (int i = 0; i < MAP_DEPTH; i++) begin
      copy_a[i]    = '0;
      copy_b[i]    = '0;
      live_is_b[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, stamp wrap, ignored fields, back-to-back commits
    foreach (directed_rows[i]) begin
      row    = directed_rows[i];
      t      = '{row.cmd, row.idx, row.addr, row.vbeg, row.vend, row.tbeg};
      golden = '{row.g_addr, row.g_beg, row.g_end, row.g_tb};
      offer(t, row.typed, golden);
    end

    // Random traffic in three idling phases; the last one opens with a long stall
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        tx_idle_pct = 70;
        rx_idle_pct <= 13;
      end
      if (n == 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
      end
      offer(random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain outstanding lookups, then give the pipeline time to show strays
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
rtl/dbcm_pkg.sv
rtl/dbcm_ram.sv
rtl/double_buffered_commit_map.sv
tb/double_buffered_commit_map_tb.sv
